// ===== sv/shnt_pkg.sv =====
package shnt_pkg;

  localparam int IDX_W        = 20;
  localparam int POS_W        = 32;
  localparam int BC_W         = 11;
  localparam int RAD_W        = 33;
  localparam int RESULT_LIMIT = 16;
  localparam int MATCH_W      = 5;

  localparam logic [31:0] PRIME_X = 32'd73856093;
  localparam logic [31:0] PRIME_Y = 32'd19349663;
  localparam logic [31:0] PRIME_Z = 32'd83492791;

  typedef enum logic [1:0] {
    KIND_CLEAR       = 2'd0,
    KIND_INSERT      = 2'd1,
    KIND_QUERY_LOWER = 2'd2,
    KIND_QUERY_ALL   = 2'd3
  } kind_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OOR  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [3:0] ADDR_BUCKET_COUNT = 4'd0;
  localparam logic [3:0] ADDR_RADIUS_SQ    = 4'd8;

  typedef struct packed {
    logic [IDX_W-1:0]        idx;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } entry_t;

  typedef struct packed {
    logic [IDX_W-1:0] neighbour_index;
    logic             match_valid;
    logic [1:0]       status;
    logic             last;
  } result_t;

  typedef struct packed {
    logic done;
    logic oor;
  } hash_res_t;

endpackage

// ===== sv/shnt_if.sv =====
interface shnt_item_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       kind;
  logic [shnt_pkg::IDX_W-1:0]       particle_index;
  logic signed [shnt_pkg::POS_W-1:0] pos_x;
  logic signed [shnt_pkg::POS_W-1:0] pos_y;
  logic signed [shnt_pkg::POS_W-1:0] pos_z;

  modport source (output valid, kind, particle_index, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, kind, particle_index, pos_x, pos_y, pos_z, output ready);
endinterface

interface shnt_result_if;
  logic                       valid;
  logic                       ready;
  logic [shnt_pkg::IDX_W-1:0] neighbour_index;
  logic                       match_valid;
  logic [1:0]                 status;
  logic                       last;

  modport source (output valid, neighbour_index, match_valid, status, last, input ready);
  modport sink   (input valid, neighbour_index, match_valid, status, last, output ready);
endinterface

// ===== sv/shnt_hash.sv =====
module shnt_hash #(
  parameter int MAX_BUCKETS = 1024,
  parameter int GRID_PITCH  = 10,
  localparam int CW = $clog2(MAX_BUCKETS + 1),
  localparam int BW = $clog2(MAX_BUCKETS)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic signed [31:0]     pos_x,
  input  logic signed [31:0]     pos_y,
  input  logic signed [31:0]     pos_z,
  input  logic [CW-1:0]          count,
  output shnt_pkg::hash_res_t    res,
  output logic [BW-1:0]          bucket
);

  localparam int RECIP_SHIFT = 24;
  localparam int unsigned RECIP = (1 << RECIP_SHIFT) / GRID_PITCH;

  typedef enum logic [4:0] {
    H_IDLE = 5'b00001,
    H_CELL = 5'b00010,
    H_CORR = 5'b00100,
    H_MUL  = 5'b01000,
    H_MOD  = 5'b10000
  } hstate_t;

  hstate_t              state;
  logic [16:0]          mag_w [3];
  logic                 neg [3];
  logic [16:0]          q_est [3];
  logic signed [31:0]   grid_c [3];
  logic [CW-1:0]        cnt;
  logic [31:0]          h;
  logic [31:0]          hmag;
  logic [CW-1:0]        rem;
  logic [4:0]           bitc;

  logic [16:0]          mag_in [3];
  logic                 neg_in [3];
  logic [41:0]          prod [3];
  logic [27:0]          resid [3];
  logic [16:0]          q_fix [3];
  logic signed [31:0]   cell_in [3];
  logic [CW:0]          rs;
  logic [CW:0]          rs_sub;
  logic [CW-1:0]        rem_next;

  always_comb begin
    logic signed [16:0] w;
    logic signed [31:0] p [3];
    p[0] = pos_x;
    p[1] = pos_y;
    p[2] = pos_z;
    for (int a = 0; a < 3; a++) begin
      // integer part of the Q16.16 coordinate, rounded towards minus infinity
      w = {p[a][31], p[a][31:16]};
      neg_in[a] = w[16];
      mag_in[a] = w[16] ? 17'(-w) : 17'(w);
      prod[a] = 42'(mag_w[a]) * 42'(RECIP);
      resid[a] = 28'(mag_w[a]) - 28'(q_est[a]) * 28'(GRID_PITCH);
      q_fix[a] = (resid[a] >= 28'(GRID_PITCH)) ? q_est[a] + 17'd1 : q_est[a];
      cell_in[a] = neg[a] ? -$signed(32'(q_fix[a])) : $signed(32'(q_fix[a]));
    end
  end

  always_comb begin
    rs = {rem, hmag[bitc]};
    rs_sub = rs - {1'b0, cnt};
    rem_next = (rs >= {1'b0, cnt}) ? rs_sub[CW-1:0] : rs[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= H_IDLE;
      res <= '0;
    end else begin
      unique case (state)
        H_IDLE: begin
          res.done <= 1'b0;
          if (start) begin
            for (int a = 0; a < 3; a++) begin
              mag_w[a] <= mag_in[a];
              neg[a] <= neg_in[a];
            end
            cnt <= count;
            state <= H_CELL;
          end
        end
        H_CELL: begin
          res.done <= 1'b0;
          for (int a = 0; a < 3; a++) q_est[a] <= prod[a][RECIP_SHIFT+16:RECIP_SHIFT];
          state <= H_CORR;
        end
        H_CORR: begin
          res.done <= 1'b0;
          for (int a = 0; a < 3; a++) grid_c[a] <= cell_in[a];
          state <= H_MUL;
        end
        H_MUL: begin
          res.done <= 1'b0;
          h <= (grid_c[0] * $signed(shnt_pkg::PRIME_X)) ^ (grid_c[1] * $signed(shnt_pkg::PRIME_Y))
             ^ (grid_c[2] * $signed(shnt_pkg::PRIME_Z));
          state <= H_MOD;
          rem <= '0;
          bitc <= 5'd31;
        end
        H_MOD: begin
          if (cnt == '0) begin
            res.done <= 1'b1;
            res.oor <= 1'b1;
            state <= H_IDLE;
          end else begin
            rem <= rem_next;
            bitc <= bitc - 5'd1;
            res.done <= (bitc == 5'd0);
            if (bitc == 5'd0) begin
              // C remainder takes the dividend's sign: a negative nonzero one is out of range
              res.oor <= h[31] && (rem_next != '0);
              bucket <= BW'(rem_next);
              state <= H_IDLE;
            end
          end
        end
        default: begin
          res.done <= 1'b0;
          state <= H_IDLE;
        end
      endcase
    end
  end

  assign hmag = h[31] ? (32'd0 - h) : h;

endmodule

// ===== sv/spatial_hash_neighbour_table_core.sv =====
// spatial hash of points over a 3d grid with a bounded neighbour search
// items: one transaction per command (clear, insert, query lower, query all)
// results: one or more transactions per command, the final one flagged by last
// config: apb-style, bucket_count at 0x0, radius_squared at 0x8, write when idle
// one command is worked on at a time; items.ready is high only between commands
// hashing steps through the cell, correction and product states, then a
// one-bit-per-cycle remainder over the 32-bit hash
// insert: hash, then fill lookup and entry write; clear: fill sweep over MAX_BUCKETS
// query: hash, then entry read, differences, squares and test per bucket entry
// scanned, since each entry is read from the entry memory and its three axis
// squares share one 32x32 multiplier
// after reset a sweep over all MAX_BUCKETS buckets zeroes the fill memory before the
// first item is taken; config writes are accepted during it
// a result register sits on the output: when the receiver stalls, the search
// holds at the next match until that register frees
module spatial_hash_neighbour_table_core #(
  parameter int MAX_BUCKETS  = 1024,
  parameter int BUCKET_DEPTH = 16,
  parameter int GRID_PITCH   = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready,
  shnt_item_if.sink            items,
  shnt_result_if.source        results
);

  localparam int CW    = $clog2(MAX_BUCKETS + 1);
  localparam int BW    = $clog2(MAX_BUCKETS);
  localparam int FW    = $clog2(BUCKET_DEPTH + 1);
  localparam int SLOTS = MAX_BUCKETS * BUCKET_DEPTH;
  localparam int AW    = $clog2(SLOTS);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_CLR  = 9'b000000010,
    S_HASH = 9'b000000100,
    S_FILL = 9'b000001000,
    S_ERD  = 9'b000010000,
    S_DIF  = 9'b000100000,
    S_SQ   = 9'b001000000,
    S_TEST = 9'b010000000,
    S_RESP = 9'b100000000
  } state_t;

  state_t state;

  logic [shnt_pkg::BC_W-1:0]  bucket_count;
  logic [shnt_pkg::RAD_W-1:0] radius_squared;
  logic                       cfg_wr;
  logic [CW-1:0]              count_eff;

  logic [1:0]                 kind_q;
  logic [shnt_pkg::IDX_W-1:0] pidx_q;
  logic signed [31:0]         px, py, pz;

  shnt_pkg::hash_res_t        hres;
  logic [BW-1:0]              hbucket;
  logic                       hstart;
  logic [BW-1:0]              bucket_q;

  logic [FW-1:0]              fill_mem [MAX_BUCKETS];
  logic [FW-1:0]              fill_rd;
  logic                       fill_we;
  logic [BW-1:0]              fill_waddr;
  logic [FW-1:0]              fill_wdata;

  shnt_pkg::entry_t           entry_mem [SLOTS];
  shnt_pkg::entry_t           entry_rd;
  logic                       entry_we;
  logic [AW-1:0]              entry_addr;
  logic [FW-1:0]              slot_sel;

  logic [BW-1:0]              clr_cnt;
  logic                       clr_item;
  logic [FW-1:0]              lim;
  logic [FW-1:0]              slot;
  logic [31:0]                mag [3];
  logic [shnt_pkg::IDX_W-1:0] ent_idx;
  logic [63:0]                sq;
  logic [63:0]                acc;
  logic [1:0]                 ax;
  logic [shnt_pkg::MATCH_W-1:0] nmatch;
  logic                       pend_valid;
  logic [shnt_pkg::IDX_W-1:0] pend_idx;
  shnt_pkg::result_t          resp;

  logic                       ovalid;
  shnt_pkg::result_t          opay;
  logic                       out_free;
  logic                       push;
  shnt_pkg::result_t          push_pay;

  logic                       accept;
  logic                       match;
  logic                       last_entry;
  logic                       limit_hit;
  logic [31:0]                mag_sel;
  logic [64:0]                acc_sum;
  logic [32:0]                dif [3];

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = paddr[3] ? {31'd0, radius_squared} : {53'd0, bucket_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count   <= 11'd1021;
      radius_squared <= 33'd42949673;
    end else if (cfg_wr) begin
      if (paddr[3]) radius_squared <= pwdata[shnt_pkg::RAD_W-1:0];
      else          bucket_count   <= pwdata[shnt_pkg::BC_W-1:0];
    end
  end

  always_comb begin
    if (32'(bucket_count) > 32'(MAX_BUCKETS)) count_eff = CW'(MAX_BUCKETS);
    else                                      count_eff = CW'(bucket_count);
  end

  assign items.ready = (state == S_IDLE);
  assign accept      = items.valid && items.ready;
  assign hstart      = accept && (items.kind != shnt_pkg::KIND_CLEAR);

  shnt_hash #(
    .MAX_BUCKETS (MAX_BUCKETS),
    .GRID_PITCH  (GRID_PITCH)
  ) u_hash (
    .clk    (clk),
    .rst    (rst),
    .start  (hstart),
    .pos_x  (items.pos_x),
    .pos_y  (items.pos_y),
    .pos_z  (items.pos_z),
    .count  (count_eff),
    .res    (hres),
    .bucket (hbucket)
  );

  // fill memory
  always_comb begin
    fill_we    = 1'b0;
    fill_waddr = bucket_q;
    fill_wdata = fill_rd + FW'(1);
    if (state == S_CLR) begin
      fill_we    = 1'b1;
      fill_waddr = clr_cnt;
      fill_wdata = '0;
    end else if (state == S_FILL && kind_q == shnt_pkg::KIND_INSERT
                 && fill_rd < FW'(BUCKET_DEPTH)) begin
      fill_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (fill_we) fill_mem[fill_waddr] <= fill_wdata;
    fill_rd <= fill_mem[hbucket];
  end

  // entry memory
  assign slot_sel   = (state == S_FILL) ? fill_rd : slot;
  assign entry_addr = AW'(32'(bucket_q) * 32'(BUCKET_DEPTH) + 32'(slot_sel));
  assign entry_we   = (state == S_FILL) && (kind_q == shnt_pkg::KIND_INSERT)
                      && (fill_rd < FW'(BUCKET_DEPTH));

  always_ff @(posedge clk) begin
    if (entry_we) entry_mem[entry_addr] <= '{idx: pidx_q, x: px, y: py, z: pz};
    entry_rd <= entry_mem[entry_addr];
  end

  // distance datapath
  always_comb begin
    dif[0] = 33'(px) - 33'(entry_rd.x);
    dif[1] = 33'(py) - 33'(entry_rd.y);
    dif[2] = 33'(pz) - 33'(entry_rd.z);
    unique case (ax)
      2'd0:    mag_sel = mag[0];
      2'd1:    mag_sel = mag[1];
      2'd2:    mag_sel = mag[2];
      default: mag_sel = '0;
    endcase
    acc_sum    = {1'b0, acc} + {1'b0, sq};
    match      = (acc < {31'd0, radius_squared})
                 && (kind_q == shnt_pkg::KIND_QUERY_ALL || ent_idx < pidx_q);
    last_entry = (32'(slot) + 32'd1 == 32'(lim));
    limit_hit  = match && (32'(nmatch) == shnt_pkg::RESULT_LIMIT - 1);
  end

  // result register
  assign out_free = !ovalid || results.ready;

  always_comb begin
    push     = 1'b0;
    push_pay = resp;
    if (state == S_RESP && out_free) begin
      push = 1'b1;
    end else if (state == S_TEST && match && pend_valid && out_free) begin
      push     = 1'b1;
      push_pay = '{neighbour_index: pend_idx, match_valid: 1'b1,
                   status: shnt_pkg::ST_OK, last: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (push) begin
      ovalid <= 1'b1;
    end else if (results.ready) begin
      ovalid <= 1'b0;
    end
    if (push) opay <= push_pay;
  end

  assign results.valid           = ovalid;
  assign results.neighbour_index = opay.neighbour_index;
  assign results.match_valid     = opay.match_valid;
  assign results.status          = opay.status;
  assign results.last            = opay.last;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      clr_cnt    <= '0;
      clr_item   <= 1'b0;
      pend_valid <= 1'b0;
      nmatch     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            kind_q   <= items.kind;
            pidx_q   <= items.particle_index;
            px       <= items.pos_x;
            py       <= items.pos_y;
            pz       <= items.pos_z;
            nmatch   <= '0;
            pend_valid <= 1'b0;
            if (items.kind == shnt_pkg::KIND_CLEAR) begin
              clr_cnt  <= '0;
              clr_item <= 1'b1;
              state    <= S_CLR;
            end else begin
              state <= S_HASH;
            end
          end
        end
        S_CLR: begin
          clr_cnt <= clr_cnt + BW'(1);
          if (clr_cnt == BW'(MAX_BUCKETS - 1)) begin
            resp  <= '{neighbour_index: '0, match_valid: 1'b0,
                       status: shnt_pkg::ST_OK, last: 1'b1};
            state <= clr_item ? S_RESP : S_IDLE;
          end
        end
        S_HASH: begin
          if (hres.done) begin
            bucket_q <= hbucket;
            if (hres.oor) begin
              if (kind_q == shnt_pkg::KIND_INSERT)
                resp <= '{neighbour_index: '0, match_valid: 1'b0,
                          status: shnt_pkg::ST_OOR, last: 1'b1};
              else
                resp <= '{neighbour_index: pidx_q, match_valid: 1'b1,
                          status: shnt_pkg::ST_OOR, last: 1'b1};
              state <= S_RESP;
            end else begin
              state <= S_FILL;
            end
          end
        end
        S_FILL: begin
          if (kind_q == shnt_pkg::KIND_INSERT) begin
            resp <= '{neighbour_index: '0, match_valid: 1'b0,
                      status: (fill_rd < FW'(BUCKET_DEPTH)) ? shnt_pkg::ST_OK
                                                            : shnt_pkg::ST_FULL,
                      last: 1'b1};
            state <= S_RESP;
          end else if (fill_rd == '0) begin
            resp  <= '{neighbour_index: '0, match_valid: 1'b0,
                       status: shnt_pkg::ST_OK, last: 1'b1};
            state <= S_RESP;
          end else begin
            lim   <= fill_rd;
            slot  <= '0;
            state <= S_ERD;
          end
        end
        S_ERD: begin
          state <= S_DIF;
        end
        S_DIF: begin
          for (int a = 0; a < 3; a++)
            mag[a] <= dif[a][32] ? 32'(33'd0 - dif[a]) : dif[a][31:0];
          ent_idx <= entry_rd.idx;
          sq      <= '0;
          acc     <= '0;
          ax      <= '0;
          state   <= S_SQ;
        end
        S_SQ: begin
          sq  <= 64'(mag_sel) * 64'(mag_sel);
          acc <= acc_sum[64] ? '1 : acc_sum[63:0];
          ax  <= ax + 2'd1;
          if (ax == 2'd3) state <= S_TEST;
        end
        S_TEST: begin
          // a new match first pushes the one held back, so last can be set on the final one
          if (!(match && pend_valid && !out_free)) begin
            if (match) begin
              pend_idx <= ent_idx;
              nmatch   <= nmatch + shnt_pkg::MATCH_W'(1);
            end
            pend_valid <= !(last_entry || limit_hit) && (match || pend_valid);
            if (last_entry || limit_hit) begin
              if (match)
                resp <= '{neighbour_index: ent_idx, match_valid: 1'b1,
                          status: shnt_pkg::ST_OK, last: 1'b1};
              else if (pend_valid)
                resp <= '{neighbour_index: pend_idx, match_valid: 1'b1,
                          status: shnt_pkg::ST_OK, last: 1'b1};
              else
                resp <= '{neighbour_index: '0, match_valid: 1'b0,
                          status: shnt_pkg::ST_OK, last: 1'b1};
              state <= S_RESP;
            end else begin
              slot  <= slot + FW'(1);
              state <= S_ERD;
            end
          end
        end
        S_RESP: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    accept |=> !items.ready)
    else $error("item taken while another is in progress");

  a_match_limit: assert property (@(posedge clk) disable iff (rst)
    32'(nmatch) <= shnt_pkg::RESULT_LIMIT)
    else $error("match count beyond result limit");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_we |-> fill_wdata <= FW'(BUCKET_DEPTH))
    else $error("bucket fill beyond depth");

  a_point_not_full: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.match_valid) |-> results.status != shnt_pkg::ST_FULL)
    else $error("full status on a result carrying a point");

  a_hash_owner: assert property (@(posedge clk) disable iff (rst)
    hres.done |-> state == S_HASH)
    else $error("hash finished outside hash wait");

endmodule

// ===== tb/sv/spatial_hash_neighbour_table_core_tb.sv =====
`timescale 1ns / 100ps

module spatial_hash_neighbour_table_core_tb;

  localparam int NBUCKETS   = 1024;
  localparam int DEPTH      = 16;
  localparam int PITCH      = 10;
  localparam int CYCLE_CAP  = 2000000;
  localparam logic [63:0] SQ_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  shnt_item_if   item_bus();
  shnt_result_if res_bus();

  spatial_hash_neighbour_table_core u_top (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .items(item_bus), .results(res_bus)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow of the table and registers
  int unsigned     bucket_count_q;
  logic [32:0]     radius_sq_q;
  int              fill_q[NBUCKETS];
  logic [19:0]     slot_idx[NBUCKETS*DEPTH];
  logic [31:0]     slot_x[NBUCKETS*DEPTH];
  logic [31:0]     slot_y[NBUCKETS*DEPTH];
  logic [31:0]     slot_z[NBUCKETS*DEPTH];
  shnt_pkg::result_t pending_results[$];

  int  mismatches = 0;
  int  cycles = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  match_results = 0;
  int  oor_results = 0;
  int  full_results = 0;
  bit  no_idle = 1'b0;

  function automatic int bucket_of(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    int cx, cy, cz, cnt, hs, r;
    logic [31:0] h;
    cnt = bucket_count_q;
    if (cnt == 0) return -1;
    if (cnt > NBUCKETS) cnt = NBUCKETS;
    // floor of q16.16 is the arithmetic top half, then truncating divide
    cx = int'($signed(x[31:16])) / PITCH;
    cy = int'($signed(y[31:16])) / PITCH;
    cz = int'($signed(z[31:16])) / PITCH;
    h = (32'(cx) * shnt_pkg::PRIME_X) ^ (32'(cy) * shnt_pkg::PRIME_Y) ^
        (32'(cz) * shnt_pkg::PRIME_Z);
    hs = h;
    r = hs % cnt;
    return (r < 0) ? -1 : r;
  endfunction

  function automatic logic [63:0] axis_sq(logic [31:0] a, logic [31:0] b);
    longint d;
    logic [63:0] m;
    d = longint'($signed(a)) - longint'($signed(b));
    m = (d < 0) ? -d : d;
    return m * m;
  endfunction

  function automatic void push_result(logic [19:0] idx, logic mv, logic [1:0] st, logic lst);
    shnt_pkg::result_t r;
    r.neighbour_index = idx;
    r.match_valid = mv;
    r.status = st;
    r.last = lst;
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic void predict_item(shnt_pkg::kind_t k, logic [19:0] idx,
                                       logic [31:0] x, logic [31:0] y, logic [31:0] z);
    int b, n, s;
    logic [65:0] d2;
    if (k == shnt_pkg::KIND_CLEAR) begin
      foreach (fill_q[i]) fill_q[i] = 0;
      push_result('0, 1'b0, shnt_pkg::ST_OK, 1'b1);
      return;
    end
    b = bucket_of(x, y, z);
    if (k == shnt_pkg::KIND_INSERT) begin
      if (b < 0) push_result('0, 1'b0, shnt_pkg::ST_OOR, 1'b1);
      else if (fill_q[b] >= DEPTH) push_result('0, 1'b0, shnt_pkg::ST_FULL, 1'b1);
      else begin
        s = b * DEPTH + fill_q[b];
        slot_idx[s] = idx; slot_x[s] = x; slot_y[s] = y; slot_z[s] = z;
        fill_q[b]++;
        push_result('0, 1'b0, shnt_pkg::ST_OK, 1'b1);
      end
      return;
    end
    if (b < 0) begin
      push_result(idx, 1'b1, shnt_pkg::ST_OOR, 1'b1);
      return;
    end
    n = 0;
    for (int i = 0; i < fill_q[b] && n < shnt_pkg::RESULT_LIMIT; i++) begin
      s = b * DEPTH + i;
      d2 = 66'(axis_sq(x, slot_x[s])) + 66'(axis_sq(y, slot_y[s])) +
           66'(axis_sq(z, slot_z[s]));
      if (d2 > 66'(SQ_MAX)) d2 = 66'(SQ_MAX);
      if (d2 >= 66'(radius_sq_q)) continue;
      if (k == shnt_pkg::KIND_QUERY_LOWER && !(slot_idx[s] < idx)) continue;
      push_result(slot_idx[s], 1'b1, shnt_pkg::ST_OK, 1'b0);
      n++;
    end
    if (n == 0) push_result('0, 1'b0, shnt_pkg::ST_OK, 1'b1);
    else pending_results[$].last = 1'b1;
  endfunction

  task automatic send_item(shnt_pkg::kind_t k, logic [19:0] idx,
                           logic [31:0] x, logic [31:0] y, logic [31:0] z);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    repeat (gap) @(negedge clk);
    item_bus.kind = k;
    item_bus.particle_index = idx;
    item_bus.pos_x = x;
    item_bus.pos_y = y;
    item_bus.pos_z = z;
    item_bus.valid = 1'b1;
    do @(posedge clk); while (!item_bus.ready);
    predict_item(k, idx, x, y, z);
    items_sent++;
    @(negedge clk);
    item_bus.valid = 1'b0;
  endtask

  task automatic drain;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
  endtask

  // registers are written only once the table has gone quiet
  task automatic write_reg(logic [3:0] addr, logic [63:0] value);
    drain();
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = addr; pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == shnt_pkg::ADDR_BUCKET_COUNT) bucket_count_q = value[10:0];
    else radius_sq_q = value[32:0];
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  function automatic logic [31:0] jitter(logic [31:0] c, int span);
    return c + 32'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  // a random point whose hash lands in range (or out of it when asked)
  task automatic pick_point(bit want_oor, output logic [31:0] x, y, z);
    int tries;
    tries = 0;
    do begin
      x = ($urandom_range(0, 3) == 0) ? $urandom() :
          32'($signed($urandom_range(0, 400000)) - 200000) << 8;
      y = $urandom();
      z = ($urandom_range(0, 1) == 0) ? $urandom() : $urandom_range(0, 1 << 24);
      tries++;
    end while (((bucket_of(x, y, z) < 0) != want_oor) && tries < 200);
  endtask

  always @(posedge clk) cycles++;

  always @(posedge clk) begin
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver with random back-pressure
  initial begin
    res_bus.ready = 1'b0;
    forever begin
      int stall;
      stall = no_idle ? 0 : $urandom_range(0, 3);
      repeat (stall) begin
        res_bus.ready = 1'b0;
        @(negedge clk);
      end
      res_bus.ready = 1'b1;
      do @(posedge clk); while (!(res_bus.valid && !rst));
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    shnt_pkg::result_t want;
    if (!rst && res_bus.valid && res_bus.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transaction: idx %0d mv %0d st %0d last %0d",
                   res_bus.neighbour_index, res_bus.match_valid, res_bus.status,
                   res_bus.last);
      end else begin
        want = pending_results.pop_front();
        if (want.match_valid && want.status == shnt_pkg::ST_OK) match_results++;
        if (want.status == shnt_pkg::ST_OOR) oor_results++;
        if (want.status == shnt_pkg::ST_FULL) full_results++;
        if (res_bus.neighbour_index !== want.neighbour_index ||
            res_bus.match_valid !== want.match_valid ||
            res_bus.status !== want.status || res_bus.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: got idx %0d mv %0d st %0d last %0d,",
                      " expected idx %0d mv %0d st %0d last %0d"},
                     res_bus.neighbour_index, res_bus.match_valid, res_bus.status,
                     res_bus.last, want.neighbour_index, want.match_valid,
                     want.status, want.last);
        end
      end
    end
  end

  task automatic test_directed;
    logic [31:0] x, y, z;
    send_item(shnt_pkg::KIND_CLEAR, 20'hFFFFF, '1, '1, '1);
    pick_point(1'b0, x, y, z);
    send_item(shnt_pkg::KIND_INSERT, 20'd5, x, y, z);
    send_item(shnt_pkg::KIND_INSERT, 20'd9, x + 32'd100, y, z - 32'd50);
    send_item(shnt_pkg::KIND_INSERT, 20'hFFFFF, x, y + 32'd10, z);
    send_item(shnt_pkg::KIND_INSERT, 20'd0, x + 32'd20000, y, z);
    send_item(shnt_pkg::KIND_QUERY_ALL, 20'd7, x, y, z);
    send_item(shnt_pkg::KIND_QUERY_LOWER, 20'd7, x, y, z);
    send_item(shnt_pkg::KIND_QUERY_LOWER, 20'd0, x, y, z);
    send_item(shnt_pkg::KIND_QUERY_LOWER, 20'hFFFFF, x + 32'd10, y, z);
    send_item(shnt_pkg::KIND_QUERY_ALL, 20'd1, x + 32'd30000, y, z);
    // extremes of the position range
    send_item(shnt_pkg::KIND_INSERT, 20'd11, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_item(shnt_pkg::KIND_INSERT, 20'd12, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(shnt_pkg::KIND_INSERT, 20'd13, 32'h0, 32'h0, 32'h0);
    send_item(shnt_pkg::KIND_QUERY_ALL, 20'd14, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000);
    send_item(shnt_pkg::KIND_QUERY_ALL, 20'd15, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h7FFF_FFFF);
    send_item(shnt_pkg::KIND_QUERY_ALL, 20'd16, 32'h0, 32'h0, 32'h0);
    pick_point(1'b1, x, y, z);
    send_item(shnt_pkg::KIND_INSERT, 20'd17, x, y, z);
    send_item(shnt_pkg::KIND_QUERY_LOWER, 20'hABCDE, x, y, z);
    send_item(shnt_pkg::KIND_CLEAR, 20'd0, 32'h0, 32'h0, 32'h0);
    send_item(shnt_pkg::KIND_QUERY_ALL, 20'd5, 32'h0, 32'h0, 32'h0);
  endtask

  // a single bucket, seventeen inserts, and a search capped at sixteen
  task automatic test_full_bucket;
    logic [31:0] x, y, z;
    write_reg(shnt_pkg::ADDR_BUCKET_COUNT, 64'd1);
    write_reg(shnt_pkg::ADDR_RADIUS_SQ, 64'h1_0000_0000);
    send_item(shnt_pkg::KIND_CLEAR, 20'd0, '0, '0, '0);
    pick_point(1'b0, x, y, z);
    for (int i = 0; i < 17; i++)
      send_item(shnt_pkg::KIND_INSERT, 20'(i * 3 + 1), jitter(x, 2000), jitter(y, 2000), z);
    send_item(shnt_pkg::KIND_QUERY_ALL, 20'd100, x, y, z);
    send_item(shnt_pkg::KIND_QUERY_LOWER, 20'd20, x, y, z);
  endtask

  task automatic test_zero_count;
    logic [31:0] x, y, z;
    write_reg(shnt_pkg::ADDR_BUCKET_COUNT, 64'd0);
    for (int i = 0; i < 4; i++) begin
      pick_point(1'b0, x, y, z);
      send_item(shnt_pkg::kind_t'(i), 20'($urandom()), x, y, z);
    end
  endtask

  // lowering the count strands entries in buckets above it
  task automatic test_stale_buckets;
    logic [31:0] x, y, z;
    write_reg(shnt_pkg::ADDR_BUCKET_COUNT, 64'd2047);
    write_reg(shnt_pkg::ADDR_RADIUS_SQ, 64'd0);
    send_item(shnt_pkg::KIND_CLEAR, 20'd0, '0, '0, '0);
    pick_point(1'b0, x, y, z);
    send_item(shnt_pkg::KIND_INSERT, 20'd40, x, y, z);
    send_item(shnt_pkg::KIND_QUERY_ALL, 20'd41, x, y, z);
    write_reg(shnt_pkg::ADDR_RADIUS_SQ, 64'h1_0000_0000);
    send_item(shnt_pkg::KIND_QUERY_ALL, 20'd41, x, y, z);
    for (int i = 0; i < 6; i++) begin
      pick_point(1'b0, x, y, z);
      send_item(shnt_pkg::KIND_INSERT, 20'(50 + i), x, y, z);
    end
    write_reg(shnt_pkg::ADDR_BUCKET_COUNT, 64'd3);
    for (int i = 0; i < 4; i++) begin
      pick_point(1'b0, x, y, z);
      send_item(shnt_pkg::KIND_INSERT, 20'(60 + i), x, y, z);
      send_item(shnt_pkg::KIND_QUERY_ALL, 20'(70 + i), x, y, z);
    end
  endtask

  // clusters of nearby inserts then searches around them, with some noise
  task automatic test_random(int budget, int count, logic [32:0] radius);
    logic [31:0] cx, cy, cz;
    int left, span;
    shnt_pkg::kind_t k;
    write_reg(shnt_pkg::ADDR_BUCKET_COUNT, 64'(count));
    write_reg(shnt_pkg::ADDR_RADIUS_SQ, 64'(radius));
    left = budget;
    while (left > 0) begin
      no_idle = ($urandom_range(0, 4) == 0);
      pick_point($urandom_range(0, 5) == 0, cx, cy, cz);
      span = ($urandom_range(0, 1) == 0) ? 4000 : 30000;
      if ($urandom_range(0, 7) == 0) begin
        send_item(shnt_pkg::KIND_CLEAR, 20'($urandom()), $urandom(), $urandom(), $urandom());
        left--;
      end
      repeat ($urandom_range(1, 12)) begin
        send_item(shnt_pkg::KIND_INSERT, 20'($urandom()), jitter(cx, span), jitter(cy, span),
                  jitter(cz, span));
        left--;
      end
      repeat ($urandom_range(1, 6)) begin
        k = ($urandom_range(0, 1) == 0) ? shnt_pkg::KIND_QUERY_LOWER
                                        : shnt_pkg::KIND_QUERY_ALL;
        send_item(k, 20'($urandom()), jitter(cx, span), jitter(cy, span), jitter(cz, span));
        left--;
      end
      if ($urandom_range(0, 3) == 0) begin
        send_item(shnt_pkg::kind_t'($urandom_range(1, 3)), 20'($urandom()), $urandom(),
                  $urandom(), $urandom());
        left--;
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    item_bus.valid = 1'b0;
    item_bus.kind = shnt_pkg::KIND_CLEAR;
    item_bus.particle_index = '0;
    item_bus.pos_x = '0;
    item_bus.pos_y = '0;
    item_bus.pos_z = '0;
    bucket_count_q = 1021;
    radius_sq_q = 33'd42949673;
    foreach (fill_q[i]) fill_q[i] = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_full_bucket();
    test_zero_count();
    test_stale_buckets();
    test_random(70, 1021, 33'd42949673);
    test_random(70, 7, 33'h1_0000_0000);
    test_random(50, 1024, 33'd400000000);
    test_random(40, 2, 33'd0);
    test_random(40, 1, 33'd42949673);

    drain();
    repeat (200) @(posedge clk);
    $display("%0d items sent, %0d transactions checked (%0d matches, %0d out of range, %0d full)",
             items_sent, results_seen, match_results, oor_results, full_results);
    $display("bucket counts 0, 1, 2, 3, 7, 1021, 1024, 2047; radius 0 up to 2^32");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches,
               pending_results.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/shnt_pkg.sv
sv/shnt_if.sv
sv/shnt_hash.sv
sv/spatial_hash_neighbour_table_core.sv
tb/sv/spatial_hash_neighbour_table_core_tb.sv
